### rtl/pidc_pkg.sv
// Shared types and constants for the clamped-integral PID core.
package pidc_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned GainW  = 16;
    localparam int unsigned DiffW  = DataW + 1;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned FracGainW = 12;
    // three products of a Q4.12 gain and a 33-bit operand, summed
    localparam int unsigned ProdW  = GainW + DiffW;
    localparam int unsigned AccW   = ProdW + 3;

    localparam logic signed [GainW-1:0] KpReset   = 16'sd1024;
    localparam logic signed [GainW-1:0] KiReset   = 16'sd410;
    localparam logic signed [GainW-1:0] KdReset   = 16'sd3277;
    localparam logic signed [DataW-1:0] UpperReset = 32'sd622592;
    localparam logic signed [DataW-1:0] LowerReset = 32'sh8000_0000;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_KP    = 3'd0,
        CFG_KI    = 3'd1,
        CFG_KD    = 3'd2,
        CFG_UPPER = 3'd3,
        CFG_LOWER = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DataW-1:0] err;
        logic signed [DataW-1:0] sum;
        logic signed [DiffW-1:0] diff;
    } t_sum_item;

    typedef struct packed {
        logic signed [GainW-1:0] kp;
        logic signed [GainW-1:0] ki;
        logic signed [GainW-1:0] kd;
    } t_gains;

endpackage

### rtl/pidc_sum.sv
// Error-sum accumulator with clamp, previous-error register and first pipeline stage.
module pidc_sum (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [pidc_pkg::DataW-1:0]  i_error_sample,
    input  logic                               i_start_req,
    input  logic signed [pidc_pkg::DataW-1:0]  i_upper,
    input  logic signed [pidc_pkg::DataW-1:0]  i_lower,
    output logic                               o_valid,
    input  logic                               i_ready,
    output pidc_pkg::t_sum_item                o_item
);

    logic signed [pidc_pkg::DataW-1:0] r_error_sum, n_error_sum;
    logic signed [pidc_pkg::DataW-1:0] r_prev_error;
    logic                              r_valid;
    pidc_pkg::t_sum_item               r_item;
    logic signed [pidc_pkg::DataW-1:0] w_sum_base, w_prev_base;
    logic signed [pidc_pkg::DataW:0]   w_sum_raw, w_sum_hi;
    logic                              w_accept;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        w_sum_base  = i_start_req ? '0 : r_error_sum;
        w_prev_base = i_start_req ? '0 : r_prev_error;
        w_sum_raw   = {w_sum_base[pidc_pkg::DataW-1], w_sum_base}
                    + {i_error_sample[pidc_pkg::DataW-1], i_error_sample};
        // upper clamp first, lower clamp last so it wins on crossed limits
        w_sum_hi = (w_sum_raw > $signed({i_upper[pidc_pkg::DataW-1], i_upper}))
                 ? $signed({i_upper[pidc_pkg::DataW-1], i_upper}) : w_sum_raw;
        if (w_sum_hi < $signed({i_lower[pidc_pkg::DataW-1], i_lower})) begin
            n_error_sum = i_lower;
        end else begin
            n_error_sum = w_sum_hi[pidc_pkg::DataW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum  <= '0;
            r_prev_error <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (w_accept) begin
                r_error_sum  <= n_error_sum;
                r_prev_error <= i_error_sample;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.err  <= i_error_sample;
            r_item.sum  <= n_error_sum;
            r_item.diff <= {i_error_sample[pidc_pkg::DataW-1], i_error_sample}
                         - {w_prev_base[pidc_pkg::DataW-1], w_prev_base};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    a_sum_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_rst_n) |=> (r_error_sum <= $past(i_upper)
                                   || r_error_sum == $past(i_lower)))
        else $error("error sum escaped its clamp");

    a_prev_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_rst_n) |=> (r_prev_error == $past(i_error_sample)
                                   && r_item.sum == r_error_sum))
        else $error("state and staged sum disagree");

endmodule

### rtl/pidc_mac.sv
// Gain products, rounding and 32-bit saturation, two pipeline stages.
module pidc_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pidc_pkg::t_gains                   i_gains,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  pidc_pkg::t_sum_item                i_item,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [pidc_pkg::DataW-1:0]  o_drive
);

    localparam int unsigned ShW = pidc_pkg::AccW - pidc_pkg::FracGainW;
    localparam logic signed [ShW-1:0] RoundMax =
        {{(ShW-pidc_pkg::DataW+1){1'b0}}, {(pidc_pkg::DataW-1){1'b1}}};
    localparam logic signed [ShW-1:0] RoundMin =
        {{(ShW-pidc_pkg::DataW+1){1'b1}}, {(pidc_pkg::DataW-1){1'b0}}};

    logic                                  r_v2, r_v3;
    logic signed [pidc_pkg::ProdW-1:0]     r_p_kp, r_p_ki, r_p_kd;
    logic signed [pidc_pkg::ProdW-1:0]     w_p_kp, w_p_ki, w_p_kd;
    logic signed [pidc_pkg::DataW-1:0]     r_drive;
    logic signed [pidc_pkg::AccW-1:0]      w_acc;
    logic signed [ShW-1:0]                 w_round;
    logic signed [pidc_pkg::DataW-1:0]     n_drive;
    logic                                  w_load3, w_en2, w_load2;

    assign w_load3 = r_v2 && (!r_v3 || i_ready);
    assign w_en2   = !r_v2 || w_load3;
    assign w_load2 = i_valid && w_en2;
    assign o_ready = w_en2;

    // operands sign-extend to the full product width
    always_comb begin
        w_p_kp = i_gains.kp * i_item.err;
        w_p_ki = i_gains.ki * i_item.sum;
        w_p_kd = i_gains.kd * i_item.diff;
    end

    always_comb begin
        w_acc = pidc_pkg::AccW'(r_p_kp) + pidc_pkg::AccW'(r_p_ki)
              + pidc_pkg::AccW'(r_p_kd)
              + pidc_pkg::AccW'(1 << (pidc_pkg::FracGainW - 1));
        // arithmetic shift floors, giving round half up
        w_round = ShW'(w_acc >>> pidc_pkg::FracGainW);
        if (w_round > RoundMax) begin
            n_drive = {1'b0, {(pidc_pkg::DataW-1){1'b1}}};
        end else if (w_round < RoundMin) begin
            n_drive = {1'b1, {(pidc_pkg::DataW-1){1'b0}}};
        end else begin
            n_drive = w_round[pidc_pkg::DataW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en2) begin
                r_v2 <= i_valid;
            end
            if (!r_v3 || i_ready) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load2) begin
            r_p_kp <= w_p_kp;
            r_p_ki <= w_p_ki;
            r_p_kd <= w_p_kd;
        end
        if (w_load3) begin
            r_drive <= n_drive;
        end
    end

    assign o_valid = r_v3;
    assign o_drive = r_drive;

    a_v3_from_v2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v3) |-> $past(r_v2))
        else $error("result valid without a staged item");

    a_load3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load3 && i_rst_n) |=> r_v3)
        else $error("loaded result not shown");

endmodule

### rtl/pid_controller_clamped_integral_core.sv
// Top level: configuration registers and the three-stage PID pipeline.
// One error item is taken per clock unless i_ready back-pressure holds o_ready
// low; the drive for an item is registered through the staged sum item, the
// product and drive registers. The feedback loop that sets this rate is the
// error-sum add and clamp, which updates the running sum and previous error at
// acceptance; the gain multiplies and the rounding/saturation follow in their
// own registered stages. start_req clears the sum and previous error ahead of
// its own sample. Configuration writes take effect immediately and should be
// made while no item is in flight; indexes 5 to 7 are ignored.
module pid_controller_clamped_integral_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [pidc_pkg::DataW-1:0]    i_error_sample,
    input  logic                                 i_start_req,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [pidc_pkg::DataW-1:0]    o_drive,
    input  logic                                 i_cfg_we,
    input  logic [pidc_pkg::CfgIdxW-1:0]         i_cfg_idx,
    input  logic [pidc_pkg::DataW-1:0]           i_cfg_data
);

    pidc_pkg::t_gains                   r_gains;
    logic signed [pidc_pkg::DataW-1:0]  r_upper, r_lower;
    pidc_pkg::t_sum_item                w_item;
    logic                               w_item_valid, w_item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.kp <= pidc_pkg::KpReset;
            r_gains.ki <= pidc_pkg::KiReset;
            r_gains.kd <= pidc_pkg::KdReset;
            r_upper    <= pidc_pkg::UpperReset;
            r_lower    <= pidc_pkg::LowerReset;
        end else if (i_cfg_we) begin
            case (pidc_pkg::t_cfg_idx'(i_cfg_idx))
                pidc_pkg::CFG_KP:    r_gains.kp <= i_cfg_data[pidc_pkg::GainW-1:0];
                pidc_pkg::CFG_KI:    r_gains.ki <= i_cfg_data[pidc_pkg::GainW-1:0];
                pidc_pkg::CFG_KD:    r_gains.kd <= i_cfg_data[pidc_pkg::GainW-1:0];
                pidc_pkg::CFG_UPPER: r_upper    <= i_cfg_data;
                pidc_pkg::CFG_LOWER: r_lower    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pidc_sum u_sum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_error_sample (i_error_sample),
        .i_start_req    (i_start_req),
        .i_upper        (r_upper),
        .i_lower        (r_lower),
        .o_valid        (w_item_valid),
        .i_ready        (w_item_ready),
        .o_item         (w_item)
    );

    pidc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gains (r_gains),
        .i_valid (w_item_valid),
        .o_ready (w_item_ready),
        .i_item  (w_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_drive (o_drive)
    );

endmodule

### test/tb_top.sv
// Testbench for the clamped-integral PID core: directed and random items checked against a predictor.
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        logic signed [pidc_pkg::DataW-1:0] err;
        logic                              start;
    } t_sample;

    localparam longint DriveMax = 64'sh0000_0000_7FFF_FFFF;
    localparam longint DriveMin = -64'sh0000_0000_8000_0000;
    localparam int     ItemsPerPhase = 120;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                o_ready;
    logic signed [pidc_pkg::DataW-1:0]   i_error_sample = '0;
    logic                                i_start_req = 1'b0;
    logic                                o_valid;
    logic                                i_ready = 1'b0;
    logic signed [pidc_pkg::DataW-1:0]   o_drive;
    logic                                i_cfg_we = 1'b0;
    logic [pidc_pkg::CfgIdxW-1:0]        i_cfg_idx = '0;
    logic [pidc_pkg::DataW-1:0]          i_cfg_data = '0;

    pid_controller_clamped_integral_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_error_sample (i_error_sample),
        .i_start_req    (i_start_req),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_drive        (o_drive),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor copy of the configuration and state
    logic signed [pidc_pkg::GainW-1:0] kp_cfg = pidc_pkg::KpReset;
    logic signed [pidc_pkg::GainW-1:0] ki_cfg = pidc_pkg::KiReset;
    logic signed [pidc_pkg::GainW-1:0] kd_cfg = pidc_pkg::KdReset;
    logic signed [pidc_pkg::DataW-1:0] sum_hi = pidc_pkg::UpperReset;
    logic signed [pidc_pkg::DataW-1:0] sum_lo = pidc_pkg::LowerReset;
    logic signed [pidc_pkg::DataW-1:0] err_sum = '0;
    logic signed [pidc_pkg::DataW-1:0] prev_err = '0;

    t_sample                           sample_q[$];
    logic signed [pidc_pkg::DataW-1:0] drive_expected[$];
    t_sample                           drv_item;
    logic                              in_taken = 1'b0;
    int                                send_idle = 36;
    int                                recv_idle = 45;
    int                                err_cnt = 0;

    function automatic logic signed [pidc_pkg::DataW-1:0] calc_drive(
        input logic signed [pidc_pkg::DataW-1:0] e,
        input logic start);
        longint s;
        longint acc;
        longint d;
        if (start) begin
            err_sum  = '0;
            prev_err = '0;
        end
        // sum formed exactly, upper clamp first, lower clamp wins last
        s = longint'(err_sum) + longint'(e);
        if (s > longint'(sum_hi)) s = sum_hi;
        if (s < longint'(sum_lo)) s = sum_lo;
        err_sum = s[pidc_pkg::DataW-1:0];
        acc = longint'(kp_cfg) * longint'(e)
            + longint'(ki_cfg) * s
            + longint'(kd_cfg) * (longint'(e) - longint'(prev_err));
        d = (acc + 2048) >>> pidc_pkg::FracGainW;
        if (d > DriveMax) d = DriveMax;
        if (d < DriveMin) d = DriveMin;
        prev_err = e;
        return d[pidc_pkg::DataW-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic write_reg(input logic [pidc_pkg::CfgIdxW-1:0] idx,
                             input logic [pidc_pkg::DataW-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            pidc_pkg::CFG_KP:    kp_cfg = data[pidc_pkg::GainW-1:0];
            pidc_pkg::CFG_KI:    ki_cfg = data[pidc_pkg::GainW-1:0];
            pidc_pkg::CFG_KD:    kd_cfg = data[pidc_pkg::GainW-1:0];
            pidc_pkg::CFG_UPPER: sum_hi = data;
            pidc_pkg::CFG_LOWER: sum_lo = data;
            default:   ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_sample(input logic signed [pidc_pkg::DataW-1:0] e, input logic start);
        t_sample it;
        it.err   = e;
        it.start = start;
        sample_q.push_back(it);
    endtask

    // wait until every item is in and every drive is out, then let the pipe settle
    task automatic drain();
        while (sample_q.size() != 0 || i_valid || drive_expected.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic signed [pidc_pkg::DataW-1:0] rand_error();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $urandom;
            4, 5, 6: return int'($urandom_range(1310720)) - 655360;
            default: return int'($urandom_range(33554432)) - 16777216;
        endcase
    endfunction

    function automatic logic [pidc_pkg::DataW-1:0] rand_gain();
        logic [pidc_pkg::GainW-1:0] g;
        case ($urandom_range(4))
            0:       g = 16'h7FFF;
            1:       g = 16'h8000;
            2, 3:    g = pidc_pkg::GainW'(int'($urandom_range(8192)) - 4096);
            default: g = pidc_pkg::GainW'($urandom);
        endcase
        // upper data bits are don't-care for gain registers
        return {16'($urandom_range(65535)), g};
    endfunction

    function automatic logic [pidc_pkg::DataW-1:0] rand_upper();
        case ($urandom_range(3))
            0:       return 32'h7FFF_FFFF;
            1:       return $urandom;
            default: return $urandom_range(1310720);
        endcase
    endfunction

    function automatic logic [pidc_pkg::DataW-1:0] rand_lower();
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return $urandom;
            default: return -int'($urandom_range(1310720));
        endcase
    endfunction

    // input acceptance and result checking
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            drive_expected.push_back(calc_drive(i_error_sample, i_start_req));
            in_taken = 1'b1;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (drive_expected.size() == 0) begin
                report_mismatch($sformatf("drive %0d with no item pending", o_drive));
            end else if (o_drive !== drive_expected[0]) begin
                report_mismatch($sformatf("drive %0d, expected %0d",
                                          o_drive, drive_expected[0]));
                void'(drive_expected.pop_front());
            end else begin
                void'(drive_expected.pop_front());
            end
        end
    end

    // item driver and receiver stalls
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    drv_item = sample_q.pop_front();
                    i_valid        <= 1'b1;
                    i_error_sample <= drv_item.err;
                    i_start_req    <= drv_item.start;
                end else begin
                    i_valid        <= 1'b0;
                    i_error_sample <= $urandom;
                    i_start_req    <= $urandom_range(1);
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle);
            in_taken = 1'b0;
        end
    end

    initial begin
        int n;
        int run;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default gains: clamp at 9.5, sum overflow, no lower clamp
        add_sample(0, 1'b1);
        add_sample(32'sd65536, 1'b0);
        add_sample(-32'sd65536, 1'b0);
        add_sample(32'sd327680, 1'b0);
        add_sample(32'sd327680, 1'b0);
        add_sample(32'sd327680, 1'b0);
        add_sample(32'sd1, 1'b0);
        add_sample(-32'sd1, 1'b0);
        add_sample(32'sh7FFF_FFFF, 1'b1);
        add_sample(32'sh7FFF_FFFF, 1'b0);
        add_sample(32'sh8000_0000, 1'b0);
        add_sample(32'sh8000_0000, 1'b0);
        add_sample(0, 1'b1);
        drain();

        // maximum gains, no clamps: drive saturates both ways
        write_reg(pidc_pkg::CFG_KP, 32'hFFFF_7FFF);
        write_reg(pidc_pkg::CFG_KI, 32'h0000_7FFF);
        write_reg(pidc_pkg::CFG_KD, 32'hA5A5_7FFF);
        write_reg(pidc_pkg::CFG_UPPER, 32'h7FFF_FFFF);
        write_reg(pidc_pkg::CFG_LOWER, 32'h8000_0000);
        add_sample(32'sh7FFF_FFFF, 1'b1);
        add_sample(32'sh8000_0000, 1'b0);
        add_sample(32'sh7FFF_FFFF, 1'b0);
        drain();

        write_reg(pidc_pkg::CFG_KP, 32'h5A5A_8000);
        write_reg(pidc_pkg::CFG_KI, 32'h0000_8000);
        write_reg(pidc_pkg::CFG_KD, 32'hFFFF_8000);
        add_sample(32'sh8000_0000, 1'b1);
        add_sample(32'sh7FFF_FFFF, 1'b0);
        add_sample(32'sh8000_0000, 1'b0);
        drain();

        // lower limit above upper limit, then writes to unused indexes
        write_reg(pidc_pkg::CFG_UPPER, -32'sd65536);
        write_reg(pidc_pkg::CFG_LOWER, 32'sd65536);
        write_reg(pidc_pkg::CfgIdxW'(pidc_pkg::CFG_LOWER + 1), 32'hFFFF_FFFF);
        write_reg(pidc_pkg::CfgIdxW'(2**pidc_pkg::CfgIdxW - 1), 32'h0000_0000);
        add_sample(0, 1'b1);
        add_sample(32'sd131072, 1'b0);
        add_sample(-32'sd131072, 1'b0);
        add_sample(32'sd262144, 1'b0);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            case (ph / 3)
                0:       begin send_idle = 36; recv_idle = 45; end
                1:       begin send_idle = 45; recv_idle = 36; end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase
            if ($urandom_range(9) < 7) write_reg(pidc_pkg::CFG_KP, rand_gain());
            if ($urandom_range(9) < 7) write_reg(pidc_pkg::CFG_KI, rand_gain());
            if ($urandom_range(9) < 7) write_reg(pidc_pkg::CFG_KD, rand_gain());
            if ($urandom_range(9) < 7) write_reg(pidc_pkg::CFG_UPPER, rand_upper());
            if ($urandom_range(9) < 7) write_reg(pidc_pkg::CFG_LOWER, rand_lower());
            if ($urandom_range(4) == 0)
                write_reg(pidc_pkg::CfgIdxW'($urandom_range(2**pidc_pkg::CfgIdxW - 1,
                                                            pidc_pkg::CFG_LOWER + 1)),
                          $urandom);
            // runs that open with a start, with an occasional stray start inside
            n = 0;
            while (n < ItemsPerPhase) begin
                run = $urandom_range(20, 3);
                for (int k = 0; k < run; k++)
                    add_sample(rand_error(), (k == 0) || ($urandom_range(19) == 0));
                n += run;
            end
            drain();
        end

        if (err_cnt == 0 && drive_expected.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
